>>> hdl/bus_syn_generator_arbiter_unit_defines.svh
// assertion macros for the bus syn generator arbiter checker
// no dependencies
`ifndef BUS_SYN_GENERATOR_ARBITER_UNIT_DEFINES_SVH
`define BUS_SYN_GENERATOR_ARBITER_UNIT_DEFINES_SVH

// implication in the same cycle, off during reset
`define BSG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsg check failed");

// implication into the next cycle, off during reset
`define BSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsg check failed");

// implication into the next cycle, active through reset
`define BSG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("bsg check failed");

`endif

>>> hdl/bsg_pkg.sv
// shared types, constants and helpers of the bus syn generator arbiter
// no dependencies
package bsg_pkg;

   localparam int COUNT_W     = 13;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYN_ENABLE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_PERIOD   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_SLACK = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYN_SYMBOL    = 3'd4;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_BYTE = 1'b1;

   localparam logic [9:0] RESET_BASE_MS      = 10'd40;
   localparam logic [9:0] RESET_TOLERANCE_MS = 10'd0;
   localparam logic [7:0] RESET_OWN_ADDRESS  = 8'd0;
   localparam logic [7:0] RESET_SYN_SYMBOL   = 8'd170;

   localparam logic [COUNT_W-1:0] ADDRESS_MS_FACTOR = COUNT_W'(10);

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
      logic       request_pending;
      logic [7:0] request_address;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       event_valid;
      logic [7:0] event_byte;
      logic       event_after_request;
      logic       generator_active;
   } rsp_type;

   typedef struct packed {
      logic       syn_enable;
      logic [9:0] fast_period;
      logic [9:0] timeout_slack;
      logic [7:0] own_address;
      logic [7:0] syn_symbol;
   } cfg_type;

   function automatic logic [COUNT_W-1:0] unique_timeout(
      input logic [9:0] base_ms,
      input logic [7:0] address,
      input logic [9:0] tolerance_ms
   );
      unique_timeout = COUNT_W'(base_ms) + COUNT_W'(address) * ADDRESS_MS_FACTOR
                       + COUNT_W'(tolerance_ms);
   endfunction

   localparam logic [COUNT_W-1:0] RESET_TIMEOUT =
      unique_timeout(RESET_BASE_MS, RESET_OWN_ADDRESS, RESET_TOLERANCE_MS);

endpackage

>>> hdl/bus_syn_generator_arbiter_unit.sv
// a request word waits in the input register, its response in the result register
// throughput: one word per cycle when the response side does not stall, set by the
// input and result registers around the combinational countdown update
// reset: synchronous; clears both stages, the generator flags and reloads the
// countdown with the reset timeout; configuration returns to its reset values
// top level of the bus syn generator arbiter; depends on bsg_pkg and submodules
module bus_syn_generator_arbiter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bsg_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bsg_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bsg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bsg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bsg_pkg::cfg_type cfg;
   bsg_pkg::req_type item;
   bsg_pkg::rsp_type result;
   logic             reload, take, advance;

   bsg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .reload    (reload)
   );

   bsg_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .take      (take),
      .advance   (advance),
      .item      (item)
   );

   bsg_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .cfg     (cfg),
      .reload  (reload),
      .result  (result)
   );

   bsg_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .result    (result),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hdl/bsg_csr.sv
// configuration registers of the bus syn generator arbiter
// depends on bsg_pkg
module bsg_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bsg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bsg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bsg_pkg::cfg_type                cfg,
   output logic                            reload
);

   bsg_pkg::cfg_type cfg_ff, cfg_in;
   logic             write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;
   assign cfg       = cfg_ff;
   assign reload    = write && (csr_index == bsg_pkg::CSR_SYN_ENABLE)
                      && csr_wdata[0] && !cfg_ff.syn_enable;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (csr_index)
            bsg_pkg::CSR_SYN_ENABLE:    cfg_in.syn_enable    = csr_wdata[0];
            bsg_pkg::CSR_FAST_PERIOD:   cfg_in.fast_period   = csr_wdata[9:0];
            bsg_pkg::CSR_TIMEOUT_SLACK: cfg_in.timeout_slack = csr_wdata[9:0];
            bsg_pkg::CSR_OWN_ADDRESS:   cfg_in.own_address   = csr_wdata[7:0];
            bsg_pkg::CSR_SYN_SYMBOL:    cfg_in.syn_symbol    = csr_wdata[7:0];
            default:                    cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.syn_enable    <= 1'b0;
         cfg_ff.fast_period   <= bsg_pkg::RESET_BASE_MS;
         cfg_ff.timeout_slack <= bsg_pkg::RESET_TOLERANCE_MS;
         cfg_ff.own_address   <= bsg_pkg::RESET_OWN_ADDRESS;
         cfg_ff.syn_symbol    <= bsg_pkg::RESET_SYN_SYMBOL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/bsg_in_stage.sv
// input register stage holding one request word
// depends on bsg_pkg
module bsg_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bsg_pkg::req_type req_data,
   input  logic             take,
   output logic             advance,
   output bsg_pkg::req_type item
);

   logic             valid_ff, valid_in;
   bsg_pkg::req_type item_ff;

   assign advance   = valid_ff & take;
   assign req_ready = !valid_ff | take;
   assign item      = item_ff;
   assign valid_in  = (req_valid & req_ready) | (valid_ff & !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

endmodule

>>> hdl/bsg_engine.sv
// countdown, generator state and per-word decision logic
// depends on bsg_pkg
module bsg_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  bsg_pkg::req_type item,
   input  bsg_pkg::cfg_type cfg,
   input  logic             reload,
   output bsg_pkg::rsp_type result
);

   logic [bsg_pkg::COUNT_W-1:0] count_ff, count_in, timeout;
   logic                        active_ff, active_in;
   logic                        sent_ff, sent_in;
   logic                        is_syn;

   assign timeout = bsg_pkg::unique_timeout(cfg.fast_period, cfg.own_address,
                                            cfg.timeout_slack);
   assign is_syn  = (item.rx_byte == cfg.syn_symbol);

   always_comb begin
      count_in  = count_ff;
      active_in = active_ff;
      sent_in   = sent_ff;
      result    = '0;
      if (item.operation == bsg_pkg::OP_TICK) begin
         if (cfg.syn_enable) begin
            if (count_ff <= bsg_pkg::COUNT_W'(1)) begin
               active_in      = 1'b1;
               result.tx_valid = 1'b1;
               result.tx_byte  = cfg.syn_symbol;
               count_in       = timeout;
            end else begin
               count_in = count_ff - bsg_pkg::COUNT_W'(1);
            end
         end
      end else begin
         if (active_ff && is_syn) begin
            count_in = bsg_pkg::COUNT_W'(cfg.fast_period);
         end else begin
            active_in = 1'b0;
            count_in  = timeout;
         end
         result.event_valid         = 1'b1;
         result.event_byte          = item.rx_byte;
         result.event_after_request = sent_ff;
         sent_in                    = 1'b0;
         if (is_syn && item.request_pending) begin
            result.tx_valid = 1'b1;
            result.tx_byte  = item.request_address;
            sent_in         = 1'b1;
         end
      end
      result.generator_active = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= bsg_pkg::RESET_TIMEOUT;
         active_ff <= 1'b0;
         sent_ff   <= 1'b0;
      end else if (reload) begin
         count_ff  <= timeout;
         active_ff <= 1'b0;
      end else if (advance) begin
         count_ff  <= count_in;
         active_ff <= active_in;
         sent_ff   <= sent_in;
      end
   end

endmodule

>>> hdl/bsg_out_stage.sv
// result register holding one response word
// depends on bsg_pkg
module bsg_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  bsg_pkg::rsp_type result,
   output logic             take,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bsg_pkg::rsp_type rsp_data
);

   logic             valid_ff, valid_in;
   bsg_pkg::rsp_type data_ff;

   assign take      = !valid_ff | rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
   assign valid_in  = advance | (valid_ff & !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= result;
      end
   end

endmodule

>>> hdl/bsg_checker.sv
// port-level checks of the bus syn generator arbiter, bound to the top level
// depends on bsg_pkg and the defines header
`include "bus_syn_generator_arbiter_unit_defines.svh"

module bsg_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bsg_pkg::rsp_type rsp_data
);

   `BSG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `BSG_ASSERT_SAME(a_tx_idle_zero, clock, reset, rsp_valid && !rsp_data.tx_valid, rsp_data.tx_byte == 8'd0)
   `BSG_ASSERT_SAME(a_event_idle_zero, clock, reset, rsp_valid && !rsp_data.event_valid, rsp_data.event_byte == 8'd0 && !rsp_data.event_after_request)
   `BSG_ASSERT_SAME(a_syn_sets_active, clock, reset, rsp_valid && rsp_data.tx_valid && !rsp_data.event_valid, rsp_data.generator_active)
   `BSG_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind bus_syn_generator_arbiter_unit bsg_checker u_bsg_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> bench/syn_arbiter_checker.sv
`timescale 1ns / 100ps
// checker of the bus syn generator arbiter: follows the register writes and the
// accepted request words, predicts each result word and compares it in order
// depends on bsg_pkg
module syn_arbiter_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  bsg_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  bsg_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [bsg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bsg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              words_waiting,
   output int                              words_checked,
   output int                              syn_sends,
   output int                              request_sends,
   output int                              flagged_bytes
);

   localparam logic [bsg_pkg::COUNT_W-1:0] MS_PER_ADDRESS = bsg_pkg::COUNT_W'(10);

   bsg_pkg::cfg_type                regs;
   logic [bsg_pkg::COUNT_W-1:0]     countdown;
   logic                            holds_bus;
   logic                            request_sent;
   bsg_pkg::rsp_type                pending_rsp_words[$];
   int                              errors = 0;
   int                              checked = 0;
   int                              syns = 0;
   int                              requests = 0;
   int                              flagged = 0;

   function automatic logic [bsg_pkg::COUNT_W-1:0] bus_timeout(input bsg_pkg::cfg_type c);
      return bsg_pkg::COUNT_W'(c.fast_period)
             + bsg_pkg::COUNT_W'(c.own_address) * MS_PER_ADDRESS
             + bsg_pkg::COUNT_W'(c.timeout_slack);
   endfunction

   task automatic write_register(input logic [bsg_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [bsg_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         bsg_pkg::CSR_SYN_ENABLE: begin
            // rising enable restarts the countdown
            if (data[0] && !regs.syn_enable) begin
               countdown = bus_timeout(regs);
               holds_bus = 1'b0;
            end
            regs.syn_enable = data[0];
         end
         bsg_pkg::CSR_FAST_PERIOD:   regs.fast_period = data;
         bsg_pkg::CSR_TIMEOUT_SLACK: regs.timeout_slack = data;
         bsg_pkg::CSR_OWN_ADDRESS:   regs.own_address = data[7:0];
         bsg_pkg::CSR_SYN_SYMBOL:    regs.syn_symbol = data[7:0];
         default: ;
      endcase
   endtask

   task automatic step_bus(input bsg_pkg::req_type w, output bsg_pkg::rsp_type r);
      r = '0;
      if (w.operation == bsg_pkg::OP_TICK) begin
         if (regs.syn_enable) begin
            if (countdown <= 1) begin
               holds_bus = 1'b1;
               r.tx_valid = 1'b1;
               r.tx_byte = regs.syn_symbol;
               countdown = bus_timeout(regs);
            end else begin
               countdown = countdown - 1'b1;
            end
         end
      end else begin
         // own syn echo keeps the fast interval, anything else backs off
         if (holds_bus && w.rx_byte == regs.syn_symbol) begin
            countdown = bsg_pkg::COUNT_W'(regs.fast_period);
         end else begin
            holds_bus = 1'b0;
            countdown = bus_timeout(regs);
         end
         r.event_valid = 1'b1;
         r.event_byte = w.rx_byte;
         r.event_after_request = request_sent;
         request_sent = 1'b0;
         if (w.rx_byte == regs.syn_symbol && w.request_pending) begin
            r.tx_valid = 1'b1;
            r.tx_byte = w.request_address;
            request_sent = 1'b1;
         end
      end
      r.generator_active = holds_bus;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         errors = errors + 1;
      end
   endtask

   always @(posedge clock) begin
      bsg_pkg::rsp_type want;
      if (reset) begin
         regs.syn_enable = 1'b0;
         regs.fast_period = bsg_pkg::RESET_BASE_MS;
         regs.timeout_slack = bsg_pkg::RESET_TOLERANCE_MS;
         regs.own_address = bsg_pkg::RESET_OWN_ADDRESS;
         regs.syn_symbol = bsg_pkg::RESET_SYN_SYMBOL;
         countdown = bus_timeout(regs);
         holds_bus = 1'b0;
         request_sent = 1'b0;
         pending_rsp_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp_words.size() == 0) begin
               $error("result word with no expectation waiting");
               errors = errors + 1;
            end else begin
               want = pending_rsp_words.pop_front();
               check_field("tx_valid", want.tx_valid, rsp_data.tx_valid);
               check_field("tx_byte", want.tx_byte, rsp_data.tx_byte);
               check_field("event_valid", want.event_valid, rsp_data.event_valid);
               check_field("event_byte", want.event_byte, rsp_data.event_byte);
               check_field("event_after_request", want.event_after_request,
                           rsp_data.event_after_request);
               check_field("generator_active", want.generator_active,
                           rsp_data.generator_active);
               checked = checked + 1;
               if (want.tx_valid && !want.event_valid) syns = syns + 1;
               if (want.tx_valid && want.event_valid) requests = requests + 1;
               if (want.event_after_request) flagged = flagged + 1;
            end
         end
         if (csr_valid && csr_ready) write_register(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            step_bus(req_data, want);
            pending_rsp_words.insert(pending_rsp_words.size(), want);
         end
      end
      fail_count    <= errors;
      words_waiting <= pending_rsp_words.size();
      words_checked <= checked;
      syn_sends     <= syns;
      request_sends <= requests;
      flagged_bytes <= flagged;
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// top of the bus syn generator arbiter bench: clock, reset, stimulus and verdict
// depends on bsg_pkg, bus_syn_generator_arbiter_unit and syn_arbiter_checker
module testbench;

   localparam int PHASE_WORDS      = 225;
   localparam int PHASE_COUNT      = 6;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int DRAIN_LIMIT      = 20000;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   bsg_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   bsg_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [bsg_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bsg_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int               fail_count;
   int               words_waiting;
   int               words_checked;
   int               syn_sends;
   int               request_sends;
   int               flagged_bytes;
   int               tx_idle_pct = 8;
   int               rx_idle_pct = 84;
   logic             long_hold_go = 1'b0;
   bsg_pkg::cfg_type bus_cfg;
   int               words_sent = 0;
   int               settings = 0;

   bus_syn_generator_arbiter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   syn_arbiter_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .words_waiting (words_waiting),
      .words_checked (words_checked),
      .syn_sends     (syn_sends),
      .request_sends (request_sends),
      .flagged_bytes (flagged_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

   // result side: random stalls plus one long hold-off
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_go && !held) begin
            held = 1'b1;
            repeat (LONG_HOLD_CYCLES) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   function automatic bsg_pkg::req_type bus_word(input logic op, input logic [7:0] rx,
                                                 input logic pending, input logic [7:0] addr);
      bsg_pkg::req_type w;
      w.operation = op;
      w.rx_byte = rx;
      w.request_pending = pending;
      w.request_address = addr;
      return w;
   endfunction

   function automatic bsg_pkg::req_type random_word(input logic op);
      return bus_word(op, 8'($urandom), 1'($urandom), 8'($urandom));
   endfunction

   function automatic bsg_pkg::cfg_type small_config(input logic enable);
      bsg_pkg::cfg_type c;
      c.syn_enable = enable;
      c.fast_period = 10'($urandom_range(0, 4));
      c.timeout_slack = 10'($urandom_range(0, 3));
      c.own_address = 8'($urandom_range(0, 2));
      c.syn_symbol = 8'($urandom);
      return c;
   endfunction

   task automatic send_word(input bsg_pkg::req_type w);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent = words_sent + 1;
   endtask

   task automatic write_csr(input logic [bsg_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [bsg_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // enable goes last so a restart picks up the new timeout
   task automatic load_config(input bsg_pkg::cfg_type c, input bit restart);
      if (restart) write_csr(bsg_pkg::CSR_SYN_ENABLE, {9'($urandom), 1'b0});
      write_csr(bsg_pkg::CSR_FAST_PERIOD, c.fast_period);
      write_csr(bsg_pkg::CSR_TIMEOUT_SLACK, c.timeout_slack);
      write_csr(bsg_pkg::CSR_OWN_ADDRESS, {2'($urandom), c.own_address});
      write_csr(bsg_pkg::CSR_SYN_SYMBOL, {2'($urandom), c.syn_symbol});
      write_csr(bsg_pkg::CSR_SYN_ENABLE, {9'($urandom), c.syn_enable});
      csr_valid <= 1'b0;
      bus_cfg = c;
      settings = settings + 1;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_waiting != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly ticks up to timeout + 2 (max 60), then syn echo, request, data bytes
   task automatic send_sequence;
      int span;
      int n;
      bsg_pkg::req_type w;
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 4)) send_word(random_word(1'($urandom)));
      end else begin
         span = bus_cfg.fast_period + bus_cfg.own_address * 10 + bus_cfg.timeout_slack + 2;
         if (span > 60) span = 60;
         repeat ($urandom_range(0, span)) send_word(random_word(bsg_pkg::OP_TICK));
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            w = random_word(bsg_pkg::OP_BYTE);
            if ($urandom_range(0, 99) < (i == 0 ? 75 : 40)) w.rx_byte = bus_cfg.syn_symbol;
            send_word(w);
         end
      end
   endtask

   initial begin
      bsg_pkg::cfg_type c;
      int target;
      int guard;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // short base, zero base reload, echo and request in one word
      c.syn_enable = 1'b1;
      c.fast_period = 10'd0;
      c.timeout_slack = 10'd1;
      c.own_address = 8'd0;
      c.syn_symbol = 8'h55;
      load_config(c, 1'b0);
      send_word(bus_word(bsg_pkg::OP_TICK, 8'hff, 1'b1, 8'hff));
      send_word(bus_word(bsg_pkg::OP_BYTE, 8'h55, 1'b1, 8'h00));
      send_word(bus_word(bsg_pkg::OP_BYTE, 8'h00, 1'b1, 8'hff));
      send_word(bus_word(bsg_pkg::OP_TICK, 8'h00, 1'b0, 8'h00));
      send_word(bus_word(bsg_pkg::OP_TICK, 8'h55, 1'b1, 8'h55));
      send_word(bus_word(bsg_pkg::OP_BYTE, 8'h55, 1'b1, 8'hff));
      send_word(bus_word(bsg_pkg::OP_BYTE, 8'h55, 1'b0, 8'h00));
      send_word(bus_word(bsg_pkg::OP_TICK, 8'h00, 1'b0, 8'h00));
      send_word(bus_word(bsg_pkg::OP_BYTE, 8'hff, 1'b0, 8'hff));
      send_word(bus_word(bsg_pkg::OP_TICK, 8'h00, 1'b0, 8'h00));
      drain();

      // generation off: ticks do nothing, requests still go out
      c.syn_enable = 1'b0;
      c.fast_period = 10'd2;
      c.timeout_slack = 10'd0;
      c.syn_symbol = 8'haa;
      load_config(c, 1'b0);
      repeat (3) send_word(bus_word(bsg_pkg::OP_TICK, 8'haa, 1'b1, 8'h5a));
      send_word(bus_word(bsg_pkg::OP_BYTE, 8'haa, 1'b1, 8'h5a));
      send_word(bus_word(bsg_pkg::OP_BYTE, 8'h00, 1'b0, 8'h00));
      drain();

      // enabling again restarts the countdown
      c.syn_enable = 1'b1;
      load_config(c, 1'b0);
      repeat (3) send_word(bus_word(bsg_pkg::OP_TICK, 8'h00, 1'b0, 8'h00));
      drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p < 2) begin
            tx_idle_pct = 8;
            rx_idle_pct = 84;
         end else if (p < 4) begin
            tx_idle_pct = 84;
            rx_idle_pct = 8;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case (p)
            0: load_config(small_config(1'b1), 1'b0);
            1: begin
               c.syn_enable = 1'b1;
               c.fast_period = 10'h3ff;
               c.timeout_slack = 10'h3ff;
               c.own_address = 8'hff;
               c.syn_symbol = 8'h00;
               load_config(c, 1'b0);
            end
            2: begin
               c = small_config(1'b0);
               c.syn_symbol = 8'hff;
               load_config(c, 1'b0);
            end
            3: begin
               c = small_config(1'b1);
               c.fast_period = 10'd0;
               c.timeout_slack = 10'd0;
               c.own_address = 8'd0;
               load_config(c, 1'b0);
            end
            4: begin
               load_config(small_config(1'b1), 1'b1);
               long_hold_go <= 1'b1;
            end
            default: load_config(small_config(1'b1), 1'($urandom));
         endcase
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) send_sequence();
         drain();
      end

      guard = 0;
      @(posedge clock);
      while (words_waiting != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard = guard + 1;
      end
      repeat (8) @(posedge clock);
      if (words_waiting != 0) $error("%0d expected result words never arrived", words_waiting);

      $display("%0d words sent and %0d results checked over %0d register settings",
               words_sent, words_checked, settings);
      $display("%0d syn sends, %0d request sends, %0d bytes flagged after a request",
               syn_sends, request_sends, flagged_bytes);
      if (fail_count == 0 && words_waiting == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> bus_syn_generator_arbiter_unit.f
+incdir+hdl
hdl/bsg_pkg.sv
hdl/bsg_csr.sv
hdl/bsg_in_stage.sv
hdl/bsg_engine.sv
hdl/bsg_out_stage.sv
hdl/bus_syn_generator_arbiter_unit.sv
hdl/bsg_checker.sv
bench/syn_arbiter_checker.sv
bench/testbench.sv
